[sv/assert_macros.svh]
// Assertion helpers included by tgr_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TGR_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TGR_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/tgr_pkg.sv]
// ----------------------------------------------------------------------------
// tgr_pkg
// Types and constants of the text glyph row rasterizer.
// ----------------------------------------------------------------------------
package tgr_pkg;

    // Font store size; a power of two so the address wraps by truncation.
    localparam int FONT_BYTES   = 16384;
    localparam int GLYPH_STRIDE = 32;
    localparam int ADDR_W       = $clog2(FONT_BYTES);

    localparam int BASE_W    = 14;
    localparam int WIDTH_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 14;
    localparam int PIX_W     = 36;
    localparam int CNT_W     = 4;

    // Operation codes
    localparam logic OP_RENDER     = 1'b0;
    localparam logic OP_FONT_WRITE = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_PRIMARY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SECONDARY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_GRAPHICS  = 2'd3;

    localparam logic [WIDTH_W-1:0] CELL_WIDTH_RESET = 4'd8;
    localparam logic [WIDTH_W-1:0] CELL_WIDTH_WIDE  = 4'd9;

    localparam logic [CNT_W-1:0] COUNT_NONE   = 4'd0;
    localparam logic [CNT_W-1:0] COUNT_NARROW = 4'd8;
    localparam logic [CNT_W-1:0] COUNT_WIDE   = 4'd9;

    // Per-item controls handed to the pixel expander.
    typedef struct packed {
        logic       op;
        logic [3:0] fg;
        logic [3:0] bg;
        logic       nine;
        logic       ninth_copy;
    } tgr_row_ctl_t;

endpackage

[sv/tgr_req_if.sv]
// ----------------------------------------------------------------------------
// tgr_req_if
// Request channel: one font write or one glyph row render.
// ----------------------------------------------------------------------------
interface tgr_req_if import tgr_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              operation;
    logic [7:0]        char_code;
    logic [7:0]        attribute;
    logic [4:0]        glyph_row;
    logic [BASE_W-1:0] font_address;
    logic [7:0]        font_data;

    modport source (
        output valid, operation, char_code, attribute, glyph_row,
               font_address, font_data,
        input  ready
    );

    modport sink (
        input  valid, operation, char_code, attribute, glyph_row,
               font_address, font_data,
        output ready
    );

endinterface

[sv/tgr_resp_if.sv]
// ----------------------------------------------------------------------------
// tgr_resp_if
// Response channel: one pixel row per request.
// ----------------------------------------------------------------------------
interface tgr_resp_if import tgr_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_row;
    logic [CNT_W-1:0] pixel_count;

    modport source (
        output valid, pixel_row, pixel_count,
        input  ready
    );

    modport sink (
        input  valid, pixel_row, pixel_count,
        output ready
    );

endinterface

[sv/tgr_ram.sv]
// ----------------------------------------------------------------------------
// tgr_ram
// Single-port RAM, registered read, read data held while re is low.
// ----------------------------------------------------------------------------
module tgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/tgr_expand.sv]
// ----------------------------------------------------------------------------
// tgr_expand
// Turns one font byte into eight or nine 4-bit color indices plus a pixel count.
// ----------------------------------------------------------------------------
module tgr_expand import tgr_pkg::*; (
    input  logic [7:0]       font_byte,
    input  tgr_row_ctl_t     ctl,
    output logic [PIX_W-1:0] pixel_row,
    output logic [CNT_W-1:0] pixel_count
);

    logic [3:0] ninth;

    always_comb
    begin
        pixel_row = '0;
        // msb first: leftmost pixel at the top nibble
        for (int i = 0; i < 8; i++)
        begin
            pixel_row[PIX_W-1-4*i -: 4] = font_byte[7-i] ? ctl.fg : ctl.bg;
        end

        ninth = (ctl.ninth_copy && font_byte[0]) ? ctl.fg : ctl.bg;
        pixel_row[3:0] = ctl.nine ? ninth : 4'd0;
        pixel_count    = ctl.nine ? COUNT_WIDE : COUNT_NARROW;

        if (ctl.op == OP_FONT_WRITE)
        begin
            pixel_row   = '0;
            pixel_count = COUNT_NONE;
        end
    end

endmodule

[sv/text_glyph_row_rasterizer.sv]
// ----------------------------------------------------------------------------
// text_glyph_row_rasterizer
// Text mode glyph row rasterizer: font store plus pixel row expansion.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake        payload
//  -------  ---  ---------------  ---------------------------------------------
//  req      in   valid/ready      operation, char_code, attribute, glyph_row,
//                                 font_address, font_data
//  resp     out  valid/ready      pixel_row, pixel_count
//  cfg      in   cfg_we           cfg_index, cfg_data (write only)
//
//  One request per clock, sustained while the response is not stalled. From accept
//  to resp.valid: address stage, font RAM read (registered port), output register.
//  The single RAM port is used once per request, read or write, which allows the
//  one-per-clock rate.
//  Reset clears valid bits and config registers; the font store is not cleared.
//  A stalled response freezes the whole pipe; req.ready drops only then.
// ----------------------------------------------------------------------------
module text_glyph_row_rasterizer import tgr_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    tgr_req_if.sink              req,
    tgr_resp_if.source           resp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    // Configuration registers
    logic [BASE_W-1:0]  base_pri_reg;
    logic [BASE_W-1:0]  base_sec_reg;
    logic [WIDTH_W-1:0] cell_width_reg;
    logic               line_gfx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_pri_reg   <= '0;
            base_sec_reg   <= '0;
            cell_width_reg <= CELL_WIDTH_RESET;
            line_gfx_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BASE_PRIMARY:   base_pri_reg   <= cfg_data[BASE_W-1:0];
                CFG_BASE_SECONDARY: base_sec_reg   <= cfg_data[BASE_W-1:0];
                CFG_CELL_WIDTH:     cell_width_reg <= cfg_data[WIDTH_W-1:0];
                CFG_LINE_GRAPHICS:  line_gfx_reg   <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Whole pipe moves together; it stops only on a held response.
    logic adv;
    logic resp_valid_reg;

    assign adv       = !resp_valid_reg || resp.ready;
    assign req.ready = adv;

    // ---- stage 0 -> 1: store address -------------------------------------
    logic [BASE_W-1:0] base_sel;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] addr_next;

    assign base_sel = req.attribute[3] ? base_sec_reg : base_pri_reg;
    // wrap modulo the store size falls out of the ADDR_W truncation
    assign rd_addr  = ADDR_W'(base_sel) + ADDR_W'(req.glyph_row)
                    + ADDR_W'(req.char_code * GLYPH_STRIDE);
    assign addr_next = (req.operation == OP_FONT_WRITE) ?
                       ADDR_W'(req.font_address) : rd_addr;

    logic              s1_valid_reg;
    logic              s1_op_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [7:0]        s1_wdata_reg;
    logic [7:0]        s1_attr_reg;
    logic              s1_gfx_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg       <= req.operation;
            s1_addr_reg     <= addr_next;
            s1_wdata_reg    <= req.font_data;
            s1_attr_reg     <= req.attribute;
            // codes 0xC0..0xFF are line graphics
            s1_gfx_code_reg <= &req.char_code[7:6];
        end
    end

    // ---- stage 1 -> 2: font store access ---------------------------------
    logic       ram_we;
    logic       ram_re;
    logic [7:0] font_byte;

    assign ram_we = adv && s1_valid_reg && (s1_op_reg == OP_FONT_WRITE);
    assign ram_re = adv && s1_valid_reg && (s1_op_reg == OP_RENDER);

    tgr_ram #(
        .WIDTH (8),
        .DEPTH (FONT_BYTES)
    ) u_font_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (s1_addr_reg),
        .wdata (s1_wdata_reg),
        .rdata (font_byte)
    );

    logic       s2_valid_reg;
    logic       s2_op_reg;
    logic [7:0] s2_attr_reg;
    logic       s2_gfx_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_op_reg       <= s1_op_reg;
            s2_attr_reg     <= s1_attr_reg;
            s2_gfx_code_reg <= s1_gfx_code_reg;
        end
    end

    // ---- stage 2 -> 3: pixel expansion into the output register ----------
    tgr_row_ctl_t     row_ctl;
    logic [PIX_W-1:0] pixel_row_next;
    logic [CNT_W-1:0] pixel_count_next;

    always_comb
    begin
        row_ctl.op         = s2_op_reg;
        row_ctl.fg         = s2_attr_reg[3:0];
        row_ctl.bg         = s2_attr_reg[7:4];  // blink bit reads as bright bg
        row_ctl.nine       = (cell_width_reg >= CELL_WIDTH_WIDE);
        row_ctl.ninth_copy = line_gfx_reg && s2_gfx_code_reg;
    end

    tgr_expand u_expand (
        .font_byte   (font_byte),
        .ctl         (row_ctl),
        .pixel_row   (pixel_row_next),
        .pixel_count (pixel_count_next)
    );

    logic [PIX_W-1:0] pixel_row_reg;
    logic [CNT_W-1:0] pixel_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            resp_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pixel_row_reg   <= pixel_row_next;
            pixel_count_reg <= pixel_count_next;
        end
    end

    assign resp.valid       = resp_valid_reg;
    assign resp.pixel_row   = pixel_row_reg;
    assign resp.pixel_count = pixel_count_reg;

endmodule

[sv/tgr_checker.sv]
// ----------------------------------------------------------------------------
// tgr_checker
// Port-level checks on the rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tgr_checker import tgr_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             req_ready,
    input logic             resp_valid,
    input logic             resp_ready,
    input logic [PIX_W-1:0] pixel_row,
    input logic [CNT_W-1:0] pixel_count
);

    // held response keeps its payload
    `TGR_ASSERT_NXT(a_resp_hold, clk, rst_n, resp_valid && !resp_ready,
        resp_valid && $stable(pixel_row) && $stable(pixel_count),
        "response changed while stalled")

    // an empty output slot never blocks requests
    `TGR_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !resp_valid, req_ready,
        "request blocked with no response pending")

    `TGR_ASSERT_IMP(a_count_legal, clk, rst_n, resp_valid,
        pixel_count == COUNT_NONE || pixel_count == COUNT_NARROW ||
        pixel_count == COUNT_WIDE,
        "illegal pixel count")

    // font write responses carry no pixels
    `TGR_ASSERT_IMP(a_write_empty, clk, rst_n,
        resp_valid && pixel_count == COUNT_NONE, pixel_row == '0,
        "font write response has pixels")

    // eight-pixel rows leave the ninth slot clear
    `TGR_ASSERT_IMP(a_ninth_clear, clk, rst_n,
        resp_valid && pixel_count == COUNT_NARROW, pixel_row[3:0] == 4'd0,
        "ninth slot set in eight-pixel mode")

endmodule

bind text_glyph_row_rasterizer tgr_checker u_tgr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_ready   (req.ready),
    .resp_valid  (resp.valid),
    .resp_ready  (resp.ready),
    .pixel_row   (resp.pixel_row),
    .pixel_count (resp.pixel_count)
);

[test/pixel_row_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_row_checker
// Watches the request, response and register ports, predicts each pixel
// row from a private font store and register copy, compares in order.
// ----------------------------------------------------------------------------
module pixel_row_checker import tgr_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    tgr_req_if                   req,
    tgr_resp_if                  resp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output int                   pending,
    output int                   errors
);

    typedef struct packed {
        logic [PIX_W-1:0] pixels;
        logic [CNT_W-1:0] count;
    } pixel_row_t;

    logic [BASE_W-1:0]  base_pri;
    logic [BASE_W-1:0]  base_sec;
    logic [WIDTH_W-1:0] cell_width;
    logic               line_gfx;
    logic [7:0]         font_copy [FONT_BYTES];
    pixel_row_t         rows_due [$];
    pixel_row_t         want;
    int                 miss_count = 0;

    assign errors = miss_count;

    function automatic pixel_row_t expand_glyph_row(logic [7:0] code, logic [7:0] attr,
                                                    logic [4:0] row);
        pixel_row_t  r;
        int          addr;
        logic [7:0]  bits;
        logic [3:0]  fg;
        logic [3:0]  bg;
        logic [3:0]  px;
        addr = (int'(attr[3] ? base_sec : base_pri) + int'(row)
                + GLYPH_STRIDE * int'(code)) % FONT_BYTES;
        bits = font_copy[addr];
        fg   = attr[3:0];
        bg   = attr[7:4];
        px   = bg;
        r.pixels = '0;
        // msb first, leftmost pixel in the top nibble
        for (int i = 0; i < 8; i++)
        begin
            px = bits[7-i] ? fg : bg;
            r.pixels[PIX_W-1-4*i -: 4] = px;
        end
        if (cell_width >= CELL_WIDTH_WIDE)
        begin
            r.pixels[3:0] = (line_gfx && code[7:6] == 2'b11) ? px : bg;
            r.count = COUNT_WIDE;
        end
        else
        begin
            r.count = COUNT_NARROW;
        end
        return r;
    endfunction

    task automatic report_miss(string what, logic [PIX_W-1:0] exp_val,
                               logic [PIX_W-1:0] act_val);
        $display("%0t: %s mismatch: expected %h actual %h", $time, what, exp_val, act_val);
        miss_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_pri   = '0;
            base_sec   = '0;
            cell_width = CELL_WIDTH_RESET;
            line_gfx   = 1'b0;
            rows_due.delete();
            pending   <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BASE_PRIMARY:   base_pri   = cfg_data[BASE_W-1:0];
                    CFG_BASE_SECONDARY: base_sec   = cfg_data[BASE_W-1:0];
                    CFG_CELL_WIDTH:     cell_width = cfg_data[WIDTH_W-1:0];
                    CFG_LINE_GRAPHICS:  line_gfx   = cfg_data[0];
                    default: ;
                endcase
            end

            // oldest expectation first, then queue the new request
            if (resp.valid && resp.ready)
            begin
                if (rows_due.size() == 0)
                begin
                    report_miss("unexpected pixel_row", '0, resp.pixel_row);
                end
                else
                begin
                    want = rows_due.pop_front();
                    if (resp.pixel_row !== want.pixels)
                        report_miss("pixel_row", want.pixels, resp.pixel_row);
                    if (resp.pixel_count !== want.count)
                        report_miss("pixel_count", PIX_W'(want.count), PIX_W'(resp.pixel_count));
                end
            end

            if (req.valid && req.ready)
            begin
                if (req.operation == OP_FONT_WRITE)
                begin
                    font_copy[req.font_address] = req.font_data;
                    rows_due.push_back('{pixels: '0, count: COUNT_NONE});
                end
                else
                begin
                    rows_due.push_back(expand_glyph_row(req.char_code, req.attribute,
                                                        req.glyph_row));
                end
            end

            pending <= rows_due.size();
        end
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives font writes and glyph row renders into the rasterizer with random
// gaps on both sides, steps through several register settings, and reports
// the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;

    import tgr_pkg::*;

    localparam int CLK_HALF         = 4;
    localparam int RESET_CYCLES     = 7;
    localparam int MAX_GAP          = 11;
    // six phases; with fills ahead of renders, ~1500 requests in all
    localparam int RANDOM_PER_PHASE = 150;
    localparam int DRAIN_CYCLES     = 8;     // pipe is three deep, plus margin
    // room for ~1.5k requests with random gaps and drains, many times over
    localparam int CYCLE_LIMIT      = 600000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    int                   pending;
    int                   errors;
    int                   cycles = 0;

    // calm = no idling on that side for a stretch
    bit                   tx_calm = 1'b0;
    bit                   rx_calm = 1'b0;
    int                   rx_hold;

    // which store bytes hold data: a render never reads an unwritten byte
    bit                   font_written [FONT_BYTES];
    // copy of the two base registers, to aim renders at written bytes
    logic [BASE_W-1:0]    base_pri_now;
    logic [BASE_W-1:0]    base_sec_now;

    tgr_req_if  req_ch ();
    tgr_resp_if resp_ch ();

    text_glyph_row_rasterizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .resp      (resp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pixel_row_checker row_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .resp      (resp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .errors    (errors)
    );

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial clk = 1'b0;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap(bit calm);
        return calm ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    // Store address a render of this cell will read under current bases.
    function automatic logic [ADDR_W-1:0] cell_addr(logic [7:0] code, logic [7:0] attr,
                                                    logic [4:0] row);
        int a;
        a = (int'(attr[3] ? base_sec_now : base_pri_now) + int'(row)
             + GLYPH_STRIDE * int'(code)) % FONT_BYTES;
        return ADDR_W'(a);
    endfunction

    // One request: idle gap with valid low, then hold valid until accepted.
    // Valid stays high on return; the next call or wait_drained lowers it.
    task automatic send_req(logic op, logic [7:0] code, logic [7:0] attr,
                            logic [4:0] row, logic [BASE_W-1:0] addr,
                            logic [7:0] data);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_calm = !tx_calm;
        gap = pick_gap(tx_calm);
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid        = 1'b1;
        req_ch.operation    = op;
        req_ch.char_code    = code;
        req_ch.attribute    = attr;
        req_ch.glyph_row    = row;
        req_ch.font_address = addr;
        req_ch.font_data    = data;
        if (op == OP_FONT_WRITE)
            font_written[addr] = 1'b1;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
    endtask

    // Put a known byte under the cell, then render it.
    task automatic render_with_byte(logic [7:0] code, logic [7:0] attr, logic [4:0] row,
                                    logic [7:0] data);
        send_req(OP_FONT_WRITE, 8'($urandom()), 8'($urandom()), 5'($urandom()),
                 cell_addr(code, attr, row), data);
        send_req(OP_RENDER, code, attr, row, 14'($urandom()), 8'($urandom()));
    endtask

    // Render; fill the byte first if nothing was written there yet.
    task automatic render_cell(logic [7:0] code, logic [7:0] attr, logic [4:0] row);
        if (!font_written[cell_addr(code, attr, row)])
            render_with_byte(code, attr, row, 8'($urandom()));
        else
            send_req(OP_RENDER, code, attr, row, 14'($urandom()), 8'($urandom()));
    endtask

    // Drop valid, wait for every row to come back, let the pipe settle.
    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
    endtask

    // New phase: block idle, then all four registers. Unused upper data bits
    // are random so every cfg_data bit toggles.
    task automatic set_config(logic [BASE_W-1:0] bp, logic [BASE_W-1:0] bs,
                              logic [WIDTH_W-1:0] cw, logic lg);
        wait_drained();
        cfg_write(CFG_BASE_PRIMARY, bp);
        cfg_write(CFG_BASE_SECONDARY, bs);
        cfg_write(CFG_CELL_WIDTH, {10'($urandom()), cw});
        cfg_write(CFG_LINE_GRAPHICS, {13'($urandom()), lg});
        @(negedge clk);
        cfg_we       = 1'b0;
        base_pri_now = bp;
        base_sec_now = bs;
    endtask

    // Mostly renders with random content; the rest are writes aimed at
    // glyph rows and plain noise writes anywhere in the store.
    task automatic random_items(int n);
        int sel;
        for (int k = 0; k < n; k++)
        begin
            sel = int'($urandom_range(0, 19));
            if (sel < 14)
                render_cell(8'($urandom()), 8'($urandom()), 5'($urandom()));
            else if (sel < 17)
                send_req(OP_FONT_WRITE, 8'($urandom()), 8'($urandom()), 5'($urandom()),
                         cell_addr(8'($urandom()), 8'($urandom()), 5'($urandom())),
                         8'($urandom()));
            else
                send_req(OP_FONT_WRITE, 8'($urandom()), 8'($urandom()), 5'($urandom()),
                         14'($urandom()), 8'($urandom()));
        end
    endtask

    // ------------------------------------------------------------------
    // Response side: after each accepted row, hold ready low for a random gap.
    // One assignment per falling edge, so ready never glitches.
    // ------------------------------------------------------------------
    initial
    begin
        resp_ch.ready = 1'b0;
        rx_hold = pick_gap(1'b0);
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                resp_ch.ready = 1'b0;
                rx_hold--;
            end
            else
            begin
                resp_ch.ready = 1'b1;
            end
            @(posedge clk);
            if (resp_ch.valid === 1'b1 && resp_ch.ready === 1'b1)
            begin
                if ($urandom_range(0, 39) == 0)
                    rx_calm = !rx_calm;
                rx_hold = pick_gap(rx_calm);
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side and verdict
    // ------------------------------------------------------------------
    initial
    begin
        req_ch.valid        = 1'b0;
        req_ch.operation    = OP_RENDER;
        req_ch.char_code    = '0;
        req_ch.attribute    = '0;
        req_ch.glyph_row    = '0;
        req_ch.font_address = '0;
        req_ch.font_data    = '0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_BASE_PRIMARY;
        cfg_data            = '0;
        base_pri_now        = '0;
        base_sec_now        = '0;
        rst_n               = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // -- reset settings: both bases 0, 8-pixel cells, no line graphics
        // address and data extremes on writes
        send_req(OP_FONT_WRITE, 8'h00, 8'h00, 5'd0, 14'h0000, 8'hFF);
        send_req(OP_FONT_WRITE, 8'hFF, 8'hFF, 5'd31, 14'h3FFF, 8'h00);
        // solid glyph byte: secondary base gives all foreground
        send_req(OP_RENDER, 8'h00, 8'h0F, 5'd0, 14'h3FFF, 8'hFF);
        // primary base, foreground 0 on bright background
        send_req(OP_RENDER, 8'h00, 8'hF0, 5'd0, 14'h0000, 8'h00);
        // top code, last row, edge bits then a mixed pattern
        render_with_byte(8'hFF, 8'h00, 5'd31, 8'h81);
        render_with_byte(8'hFF, 8'hFF, 5'd31, 8'h5A);
        // line-graphics code in 8-pixel mode: ninth slot stays empty
        render_with_byte(8'hC0, 8'h1E, 5'd5, 8'h01);
        random_items(RANDOM_PER_PHASE);

        // -- all extremes: bases at the top, 9 pixels, line graphics on
        set_config(14'h3FFF, 14'h3FFF, CELL_WIDTH_WIDE, 1'b1);
        // base + row + stride*code runs past the store end and wraps
        render_with_byte(8'hFF, 8'h87, 5'd31, 8'hA5);
        // ninth pixel copies a set eighth pixel
        render_with_byte(8'hC0, 8'h2C, 5'd7, 8'h01);
        // ninth pixel copies a clear eighth pixel (background)
        render_with_byte(8'hFF, 8'h2C, 5'd8, 8'hFE);
        // just below the line-graphics range: ninth is background
        render_with_byte(8'hBF, 8'h2C, 5'd7, 8'hFF);
        // only bit 6 set: not line graphics either
        render_with_byte(8'h7F, 8'hA3, 5'd2, 8'hFF);
        random_items(RANDOM_PER_PHASE);

        // -- cell width above nine still means 9-pixel mode
        set_config(14'h0000, 14'h3FFF, 4'd15, 1'b1);
        render_with_byte(8'hE3, 8'h9B, 5'd3, 8'hFF);
        random_items(RANDOM_PER_PHASE);

        // -- cell width zero falls back to 8-pixel mode
        set_config(14'($urandom()), 14'($urandom()), 4'd0, 1'b0);
        render_with_byte(8'hC0, 8'h4D, 5'd0, 8'hFF);
        random_items(RANDOM_PER_PHASE);

        // -- 9 pixels with line graphics off: ninth always background
        set_config(14'($urandom()), 14'($urandom()), CELL_WIDTH_WIDE, 1'b0);
        render_with_byte(8'hF1, 8'h6A, 5'd17, 8'hFF);
        random_items(RANDOM_PER_PHASE);

        // -- line graphics on but 8-pixel cells
        set_config(14'($urandom()), 14'($urandom()), CELL_WIDTH_RESET, 1'b1);
        random_items(RANDOM_PER_PHASE);

        wait_drained();
        if (errors == 0 && pending == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
